>>> rtl/afsk_nrzi_tone_modulator_macros.svh
// Assertion macros used by the AFSK modulator checker.
`ifndef AFSK_NRZI_TONE_MODULATOR_MACROS_SVH
`define AFSK_NRZI_TONE_MODULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AFSK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define AFSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/afsk_pkg.sv
// Types, constants and sine tables of the AFSK NRZI tone modulator.
package afsk_pkg;

    localparam int MAX_BITS    = 2048;
    localparam int TABLE_STEPS = 32;
    localparam int ROM_LEN     = 32;

    localparam int ADDR_W  = $clog2(MAX_BITS);
    localparam int CNT_W   = $clog2(MAX_BITS + 1);
    localparam int PHASE_W = $clog2(TABLE_STEPS);
    localparam int ROM_W   = $clog2(ROM_LEN);
    localparam int SAMPLE_W = 12;
    localparam int TICK_W  = 8;

    localparam logic [TICK_W-1:0] TPB_RESET = 8'd32;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_START   = 2'd1,
        OP_BITCLK  = 2'd2,
        OP_HIGHCLK = 2'd3
    } op_t;

    typedef struct packed {
        op_t  op;
        logic data_bit;
        logic restart_buffer;
    } item_t;

    // Same layout as m_tdata, lowest field last.
    typedef struct packed {
        logic                bit_dropped;
        logic                tone_high;
        logic                restart_high_timer;
        logic                busy_res;
        logic [SAMPLE_W-1:0] sample;
        logic                sample_valid;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    localparam logic [SAMPLE_W-1:0] ROM_HIGH [ROM_LEN] = '{
        12'd2048, 12'd2447, 12'd2831, 12'd3185, 12'd3495, 12'd3750, 12'd3939, 12'd4056,
        12'd4095, 12'd4056, 12'd3939, 12'd3750, 12'd3495, 12'd3185, 12'd2831, 12'd2447,
        12'd2048, 12'd1648, 12'd1264, 12'd910,  12'd600,  12'd345,  12'd156,  12'd39,
        12'd0,    12'd39,   12'd156,  12'd345,  12'd600,  12'd910,  12'd1264, 12'd1648
    };

    localparam logic [SAMPLE_W-1:0] ROM_LOW [ROM_LEN] = '{
        12'd2048, 12'd2268, 12'd2479, 12'd2674, 12'd2844, 12'd2984, 12'd3088, 12'd3152,
        12'd3174, 12'd3152, 12'd3088, 12'd2984, 12'd2844, 12'd2674, 12'd2479, 12'd2268,
        12'd2048, 12'd1828, 12'd1617, 12'd1422, 12'd1252, 12'd1112, 12'd1008, 12'd944,
        12'd922,  12'd944,  12'd1008, 12'd1112, 12'd1252, 12'd1422, 12'd1617, 12'd1828
    };

    // Map a phase step onto the 32-entry sine tables.
    function automatic logic [ROM_W-1:0] rom_index(input logic [PHASE_W-1:0] phase);
        logic [PHASE_W+ROM_W:0] prod;
        begin
            prod = (PHASE_W+ROM_W+1)'(phase) * (PHASE_W+ROM_W+1)'(ROM_LEN);
            rom_index = ROM_W'(prod / TABLE_STEPS);
        end
    endfunction

endpackage

>>> rtl/afsk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module afsk_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/afsk_core.sv
// Modulator state and the per-item update: bit store control, NRZI tone and sine lookup.
module afsk_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  afsk_pkg::item_t              item,
    input  logic [afsk_pkg::TICK_W-1:0]  ticks_per_bit,
    input  logic                         rd_bit,
    output afsk_pkg::mem_req_t           mem_req,
    output afsk_pkg::result_t            result
);

    logic [afsk_pkg::CNT_W-1:0]   stored_reg, stored_next;
    logic [afsk_pkg::CNT_W-1:0]   pos_reg, pos_next, pos_inc;
    logic [afsk_pkg::TICK_W-1:0]  tick_reg, tick_next, tick_inc;
    logic [afsk_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                         low_reg, low_next;
    logic                         sending_reg, sending_next;
    logic                         byp_hit_reg;
    logic                         byp_data_reg;
    logic                         store_bit;
    logic                         emit;
    logic                         use_high;
    logic                         to_high;
    logic                         dropped;
    logic [afsk_pkg::ROM_W-1:0]   idx;

    // RAM data was read in the previous cycle at pos+1; a write in that cycle to the same slot wins.
    assign store_bit = byp_hit_reg ? byp_data_reg : rd_bit;
    assign idx       = afsk_pkg::rom_index(phase_reg);

    always_comb
    begin
        stored_next   = stored_reg;
        pos_next      = pos_reg;
        tick_next     = tick_reg;
        phase_next    = phase_reg;
        low_next      = low_reg;
        sending_next  = sending_reg;
        emit          = 1'b0;
        use_high      = 1'b0;
        to_high       = 1'b0;
        dropped       = 1'b0;
        tick_inc      = tick_reg + 1'b1;
        pos_inc       = pos_reg + 1'b1;
        mem_req.we    = 1'b0;
        mem_req.waddr = stored_reg[afsk_pkg::ADDR_W-1:0];
        mem_req.wdata = item.data_bit;

        if (step)
        begin
            unique case (item.op)
                afsk_pkg::OP_LOAD:
                begin
                    if (item.restart_buffer)
                    begin
                        stored_next   = afsk_pkg::CNT_W'(1);
                        mem_req.we    = 1'b1;
                        mem_req.waddr = '0;
                    end
                    else if (stored_reg >= afsk_pkg::CNT_W'(afsk_pkg::MAX_BITS))
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        mem_req.we  = 1'b1;
                        stored_next = stored_reg + 1'b1;
                    end
                end
                afsk_pkg::OP_START:
                begin
                    phase_next   = '0;
                    pos_next     = '0;
                    tick_next    = '0;
                    low_next     = 1'b1;
                    sending_next = 1'b1;
                end
                afsk_pkg::OP_BITCLK:
                begin
                    if (sending_reg)
                    begin
                        if (tick_inc >= ticks_per_bit)
                        begin
                            tick_next = '0;
                            pos_next  = pos_inc;
                            if (pos_inc < stored_reg &&
                                pos_inc < afsk_pkg::CNT_W'(afsk_pkg::MAX_BITS))
                            begin
                                // NRZI: a zero flips the tone
                                if (!store_bit)
                                begin
                                    low_next = !low_reg;
                                    to_high  = low_reg;
                                end
                            end
                            else
                            begin
                                sending_next = 1'b0;
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                    emit = low_next;
                end
                afsk_pkg::OP_HIGHCLK:
                begin
                    emit     = !low_reg;
                    use_high = 1'b1;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase

            if (emit)
            begin
                phase_next = (phase_reg == afsk_pkg::PHASE_W'(afsk_pkg::TABLE_STEPS - 1)) ?
                             '0 : phase_reg + 1'b1;
            end
        end

        mem_req.raddr = afsk_pkg::ADDR_W'(pos_next + 1'b1);

        result.sample_valid       = emit;
        result.sample             = !emit ? '0 :
                                    use_high ? afsk_pkg::ROM_HIGH[idx] : afsk_pkg::ROM_LOW[idx];
        result.busy_res           = sending_next;
        result.restart_high_timer = to_high;
        result.tone_high          = !low_next;
        result.bit_dropped        = dropped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg  <= '0;
            pos_reg     <= '0;
            tick_reg    <= '0;
            phase_reg   <= '0;
            low_reg     <= 1'b1;
            sending_reg <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            stored_reg  <= stored_next;
            pos_reg     <= pos_next;
            tick_reg    <= tick_next;
            phase_reg   <= phase_next;
            low_reg     <= low_next;
            sending_reg <= sending_next;
            byp_hit_reg <= mem_req.we && (mem_req.waddr == mem_req.raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= mem_req.wdata;
    end

endmodule

>>> rtl/afsk_nrzi_tone_modulator.sv
// Top level of the AFSK NRZI tone modulator: stream ports, config register, bit store.
// Takes one command per clock (load bit, start, bit-clock tick, high-tone tick) and returns
// exactly one result per command, held first in the input register and then in the output
// register. Full rate holds as long as m_tready stays high; the only sustained limit is the
// bit store, a 2048 x 1 RAM with one write port and one read port, read ahead at the next
// bit position so each tick sees its bit without stalling. The store needs no clearing pass
// after reset; bits are valid once loaded. ticks_per_bit sits at APB byte address 0 and
// resets to 32; write it only while the block is idle.
module afsk_nrzi_tone_modulator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] data_bit, [1] restart_buffer, [7:2] zero
    input  logic [1:0]  s_tuser,    // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [0] sample_valid, [12:1] sample, [13] busy_res,
                                    // [14] restart_high_timer, [15] tone_high,
                                    // [16] bit_dropped, [23:17] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                         in_valid_reg;
    afsk_pkg::item_t              in_item_reg;
    logic                         out_valid_reg;
    afsk_pkg::result_t            out_res_reg;
    logic                         advance;
    logic [afsk_pkg::TICK_W-1:0]  tpb_reg;
    afsk_pkg::mem_req_t           mem_req;
    afsk_pkg::result_t            result;
    logic                         rd_bit;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg};
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {24'd0, tpb_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tpb_reg       <= afsk_pkg::TPB_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (psel && penable && pwrite && pready && !paddr[2])
            begin
                tpb_reg <= pwdata[afsk_pkg::TICK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.op             <= afsk_pkg::op_t'(s_tuser);
            in_item_reg.data_bit       <= s_tdata[0];
            in_item_reg.restart_buffer <= s_tdata[1];
        end
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

    afsk_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .item          (in_item_reg),
        .ticks_per_bit (tpb_reg),
        .rd_bit        (rd_bit),
        .mem_req       (mem_req),
        .result        (result)
    );

    afsk_ram #(
        .WIDTH (1),
        .DEPTH (afsk_pkg::MAX_BITS)
    ) u_store (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rd_bit)
    );

endmodule

>>> rtl/afsk_checker.sv
// Port-level checker for the AFSK modulator, bound to the top level.
`include "afsk_nrzi_tone_modulator_macros.svh"

module afsk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // a stalled result transaction keeps its payload
    `AFSK_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, $stable(m_tdata), "result changed under stall")
    `AFSK_ASSERT_SAME(a_quiet, m_tvalid && !m_tdata[0], m_tdata[12:1] == 12'd0, "sample without valid")
    // a switch to the high tone happens only mid-transmission
    `AFSK_ASSERT_SAME(a_switch, m_tvalid && m_tdata[14], m_tdata[15] && m_tdata[13], "bad tone switch")
    `AFSK_ASSERT_SAME(a_drop, m_tvalid && m_tdata[16], !m_tdata[0], "dropped load gave sample")

endmodule

bind afsk_nrzi_tone_modulator afsk_checker u_checker (.*);
